/* hw/rtl/bc1_bc3_block_decoder_assert.svh */
// Assertion macros shared by the block decoder modules.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef BC1_BC3_BLOCK_DECODER_ASSERT_SVH
`define BC1_BC3_BLOCK_DECODER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BC13_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BC13_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/bc13_pkg.sv */
// Shared types and constants for the BC1/BC3 block decoder.
// No dependencies; used by bc13_issue, bc13_pix_pipe and the top level.
package bc13_pkg;

  localparam logic [3:0] LAST_PIX = 4'd15;

  // One pixel's worth of work handed from the block issuer to the pixel pipeline.
  typedef struct packed {
    logic [15:0] c0;
    logic [15:0] c1;
    logic [7:0]  a0;
    logic [7:0]  a1;
    logic [1:0]  ci;
    logic [2:0]  ai;
    logic        bc3;
    logic [3:0]  idx;
    logic        last;
  } bc13_tok_t;

endpackage

/* hw/rtl/bc13_issue.sv */
// Block holding register and pixel sequencer: turns one block into 16 pixel tokens.
// Depends on bc13_pkg and bc1_bc3_block_decoder_assert.svh.
`include "bc1_bc3_block_decoder_assert.svh"

module bc13_issue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [63:0]        in_alpha_block,
  input  logic [63:0]        in_colour_block,
  input  logic               fmt_bc3,
  output logic               tok_valid,
  input  logic               tok_ready,
  output bc13_pkg::bc13_tok_t tok
);
  import bc13_pkg::*;

  logic        busy_r;
  logic [3:0]  cnt_r;
  logic [15:0] c0_r;
  logic [15:0] c1_r;
  logic [7:0]  a0_r;
  logic [7:0]  a1_r;
  logic [31:0] cidx_r;
  logic [47:0] aidx_r;
  logic        bc3_r;
  logic        in_fire;
  logic        tok_fire;

  // A new block is taken in the same cycle as the previous block's last token leaves.
  assign in_ready  = !busy_r || (tok_ready && (cnt_r == LAST_PIX));
  assign in_fire   = in_valid && in_ready;
  assign tok_valid = busy_r;
  assign tok_fire  = busy_r && tok_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (in_fire) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (tok_fire) begin
      cnt_r <= cnt_r + 4'd1;
      if (cnt_r == LAST_PIX) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Index fields shift down so the current pixel's codes always sit at the bottom.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      c0_r   <= in_colour_block[15:0];
      c1_r   <= in_colour_block[31:16];
      cidx_r <= in_colour_block[63:32];
      a0_r   <= in_alpha_block[7:0];
      a1_r   <= in_alpha_block[15:8];
      aidx_r <= in_alpha_block[63:16];
      bc3_r  <= fmt_bc3;
    end else if (tok_fire) begin
      cidx_r <= {2'b00, cidx_r[31:2]};
      aidx_r <= {3'b000, aidx_r[47:3]};
    end
  end

  always_comb begin
    tok.c0   = c0_r;
    tok.c1   = c1_r;
    tok.a0   = a0_r;
    tok.a1   = a1_r;
    tok.ci   = cidx_r[1:0];
    tok.ai   = aidx_r[2:0];
    tok.bc3  = bc3_r;
    tok.idx  = cnt_r;
    tok.last = (cnt_r == LAST_PIX);
  end

  `BC13_ASSERT_NXT(a_issue_load, in_fire, busy_r && (cnt_r == 4'd0),
                   "accepted block did not start at pixel zero")
  `BC13_ASSERT_NXT(a_issue_done, tok_fire && (cnt_r == LAST_PIX) && !in_fire, !busy_r,
                   "issuer still busy after the last pixel token")
  `BC13_ASSERT_NXT(a_issue_hold, busy_r && !tok_ready && !in_fire,
                   busy_r && $stable(cnt_r) && $stable(cidx_r),
                   "pixel token changed while stalled")

endmodule

/* hw/rtl/bc13_pix_pipe.sv */
// Four-stage pixel pipeline: decode weights, weighted sums, reciprocal divide, pack.
// Depends on bc13_pkg and bc1_bc3_block_decoder_assert.svh.
`include "bc1_bc3_block_decoder_assert.svh"

module bc13_pix_pipe (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                tok_valid,
  output logic                tok_ready,
  input  bc13_pkg::bc13_tok_t tok,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         out_pixel,
  output logic [3:0]          out_pixel_index,
  output logic                out_last
);
  import bc13_pkg::*;

  typedef enum logic [1:0] {CDIV_ONE, CDIV_TWO, CDIV_THREE} cdiv_t;
  typedef enum logic [1:0] {ADIV_ONE, ADIV_FIVE, ADIV_SEVEN} adiv_t;

  localparam logic [1:0] CI_EP0 = 2'd0;
  localparam logic [1:0] CI_EP1 = 2'd1;
  localparam logic [1:0] CI_MID = 2'd2;
  localparam logic [1:0] CI_LAST = 2'd3;
  localparam logic [2:0] AI_EP0 = 3'd0;
  localparam logic [2:0] AI_EP1 = 3'd1;
  localparam logic [2:0] AI_ZERO = 3'd6;
  localparam logic [2:0] AI_FULL = 3'd7;

  // floor(x/d) == (x * R) >> S over the whole range of each sum.
  localparam logic [19:0] RECIP3 = 20'd683;
  localparam logic [22:0] RECIP5 = 23'd1639;
  localparam logic [22:0] RECIP7 = 23'd2341;

  typedef struct packed {
    logic [2:0][7:0] e0;
    logic [2:0][7:0] e1;
    logic [7:0]      a0;
    logic [7:0]      a1;
    logic [1:0]      cwa;
    logic [1:0]      cwb;
    cdiv_t           cdiv;
    logic            czero;
    logic [2:0]      awa;
    logic [2:0]      awb;
    adiv_t           adiv;
    logic            afix;
    logic [7:0]      afixval;
    logic [3:0]      idx;
    logic            last;
  } s1_t;

  typedef struct packed {
    logic [2:0][9:0] csum;
    logic [10:0]     asum;
    cdiv_t           cdiv;
    logic            czero;
    adiv_t           adiv;
    logic            afix;
    logic [7:0]      afixval;
    logic [3:0]      idx;
    logic            last;
  } s2_t;

  typedef struct packed {
    logic [2:0][7:0] cq;
    logic [7:0]      aq;
    logic            czero;
    logic [3:0]      idx;
    logic            last;
  } s3_t;

  function automatic logic [7:0] widen5(input logic [4:0] v);
    widen5 = {v, v[4:2]};
  endfunction

  function automatic logic [7:0] widen6(input logic [5:0] v);
    widen6 = {v, v[5:4]};
  endfunction

  logic        v1_r, v2_r, v3_r, v4_r;
  logic        rdy1, rdy2, rdy3, rdy4;
  s1_t         s1_r, s1_nxt;
  s2_t         s2_r, s2_nxt;
  s3_t         s3_r, s3_nxt;
  logic [31:0] pix_r;
  logic [3:0]  idx_r;
  logic        last_r;
  logic        four;
  logic        amode7;
  logic [2:0][19:0] cprod;
  logic [22:0] aprod5;
  logic [22:0] aprod7;

  // Each stage takes new data when it is empty or its successor moves on.
  assign rdy4      = !v4_r || out_ready;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign tok_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= tok_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // Stage 1: widen endpoints and turn the index codes into weights and a divisor.
  always_comb begin
    four   = tok.bc3 || (tok.c0 > tok.c1);
    amode7 = tok.a0 > tok.a1;

    s1_nxt.e0[2] = widen5(tok.c0[15:11]);
    s1_nxt.e0[1] = widen6(tok.c0[10:5]);
    s1_nxt.e0[0] = widen5(tok.c0[4:0]);
    s1_nxt.e1[2] = widen5(tok.c1[15:11]);
    s1_nxt.e1[1] = widen6(tok.c1[10:5]);
    s1_nxt.e1[0] = widen5(tok.c1[4:0]);
    s1_nxt.a0    = tok.a0;
    s1_nxt.a1    = tok.a1;
    s1_nxt.idx   = tok.idx;
    s1_nxt.last  = tok.last;

    s1_nxt.cwa   = 2'd1;
    s1_nxt.cwb   = 2'd0;
    s1_nxt.cdiv  = CDIV_ONE;
    s1_nxt.czero = 1'b0;
    unique case (tok.ci)
      CI_EP0: begin
        s1_nxt.cwa = 2'd1;
        s1_nxt.cwb = 2'd0;
      end
      CI_EP1: begin
        s1_nxt.cwa = 2'd0;
        s1_nxt.cwb = 2'd1;
      end
      CI_MID: begin
        s1_nxt.cwa  = four ? 2'd2 : 2'd1;
        s1_nxt.cwb  = 2'd1;
        s1_nxt.cdiv = four ? CDIV_THREE : CDIV_TWO;
      end
      CI_LAST: begin
        s1_nxt.cwa   = four ? 2'd1 : 2'd0;
        s1_nxt.cwb   = four ? 2'd2 : 2'd0;
        s1_nxt.cdiv  = four ? CDIV_THREE : CDIV_ONE;
        s1_nxt.czero = !four;
      end
      default: begin
        s1_nxt.cwa = 2'd1;
        s1_nxt.cwb = 2'd0;
      end
    endcase

    s1_nxt.awa     = 3'd1;
    s1_nxt.awb     = 3'd0;
    s1_nxt.adiv    = ADIV_ONE;
    s1_nxt.afix    = 1'b0;
    s1_nxt.afixval = 8'hFF;
    priority if (!tok.bc3) begin
      // BC1 alpha is opaque; transparent black is cleared whole in the last stage.
      s1_nxt.afix = 1'b1;
    end else if (tok.ai == AI_EP0) begin
      s1_nxt.awa = 3'd1;
    end else if (tok.ai == AI_EP1) begin
      s1_nxt.awa = 3'd0;
      s1_nxt.awb = 3'd1;
    end else if (amode7) begin
      s1_nxt.awa  = 3'(4'd8 - {1'b0, tok.ai});
      s1_nxt.awb  = tok.ai - 3'd1;
      s1_nxt.adiv = ADIV_SEVEN;
    end else if (tok.ai == AI_ZERO) begin
      s1_nxt.afix    = 1'b1;
      s1_nxt.afixval = 8'h00;
    end else if (tok.ai == AI_FULL) begin
      s1_nxt.afix = 1'b1;
    end else begin
      s1_nxt.awa  = 3'(4'd6 - {1'b0, tok.ai});
      s1_nxt.awb  = tok.ai - 3'd1;
      s1_nxt.adiv = ADIV_FIVE;
    end
  end

  // Stage 2: weighted sums per channel.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      s2_nxt.csum[ch] = 10'(s1_r.cwa) * 10'(s1_r.e0[ch]) + 10'(s1_r.cwb) * 10'(s1_r.e1[ch]);
    end
    s2_nxt.asum    = 11'(s1_r.awa) * 11'(s1_r.a0) + 11'(s1_r.awb) * 11'(s1_r.a1);
    s2_nxt.cdiv    = s1_r.cdiv;
    s2_nxt.czero   = s1_r.czero;
    s2_nxt.adiv    = s1_r.adiv;
    s2_nxt.afix    = s1_r.afix;
    s2_nxt.afixval = s1_r.afixval;
    s2_nxt.idx     = s1_r.idx;
    s2_nxt.last    = s1_r.last;
  end

  // Stage 3: truncating division, by reciprocal multiplication for three, five and seven and by a shift for two.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      cprod[ch] = 20'(s2_r.csum[ch]) * RECIP3;
      unique case (s2_r.cdiv)
        CDIV_THREE: s3_nxt.cq[ch] = cprod[ch][18:11];
        CDIV_TWO:   s3_nxt.cq[ch] = s2_r.csum[ch][8:1];
        default:    s3_nxt.cq[ch] = s2_r.csum[ch][7:0];
      endcase
    end
    aprod5 = 23'(s2_r.asum) * RECIP5;
    aprod7 = 23'(s2_r.asum) * RECIP7;
    if (s2_r.afix) begin
      s3_nxt.aq = s2_r.afixval;
    end else begin
      unique case (s2_r.adiv)
        ADIV_SEVEN: s3_nxt.aq = aprod7[21:14];
        ADIV_FIVE:  s3_nxt.aq = aprod5[20:13];
        default:    s3_nxt.aq = s2_r.asum[7:0];
      endcase
    end
    s3_nxt.czero = s2_r.czero;
    s3_nxt.idx   = s2_r.idx;
    s3_nxt.last  = s2_r.last;
  end

  always_ff @(posedge clk) begin
    if (rdy1 && tok_valid) s1_r <= s1_nxt;
    if (rdy2 && v1_r) s2_r <= s2_nxt;
    if (rdy3 && v2_r) s3_r <= s3_nxt;
    if (rdy4 && v3_r) begin
      pix_r  <= s3_r.czero ? 32'h0 : {s3_r.aq, s3_r.cq[2], s3_r.cq[1], s3_r.cq[0]};
      idx_r  <= s3_r.idx;
      last_r <= s3_r.last;
    end
  end

  assign out_valid       = v4_r;
  assign out_pixel       = pix_r;
  assign out_pixel_index = idx_r;
  assign out_last        = last_r;

  `BC13_ASSERT_IMP(a_pipe_last_idx, out_valid && out_last, out_pixel_index == LAST_PIX,
                   "last flag on a pixel other than the sixteenth")
  `BC13_ASSERT_IMP(a_pipe_black_opaque, v2_r && s2_r.czero, s2_r.afix,
                   "transparent black outside the fixed-alpha path")
  `BC13_ASSERT_NXT(a_pipe_s3_hold, v3_r && !rdy4, v3_r && $stable(s3_r),
                   "stage three lost or changed a stalled pixel")

endmodule

/* hw/rtl/bc1_bc3_block_decoder.sv */
// BC1/BC3 block decoder: one block in, sixteen pixels out.
// Throughput: one pixel per cycle while out_ready holds, set by the one-pixel output.
// The next block is accepted in the cycle its predecessor's last pixel enters the pipeline.
// Reset (synchronous, active low) selects BC1 and empties the issuer and the pipeline.
// Top level: holds the format register; depends on bc13_pkg, bc13_issue, bc13_pix_pipe.
module bc1_bc3_block_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_alpha_block,
  input  logic [63:0] in_colour_block,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_pixel,
  output logic [3:0]  out_pixel_index,
  output logic        out_last,
  input  logic        cfg_write_en,
  input  logic        cfg_block_format
);
  import bc13_pkg::*;

  logic      block_format_r;
  logic      tok_valid;
  logic      tok_ready;
  bc13_tok_t tok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_format_r <= 1'b0;
    end else if (cfg_write_en) begin
      block_format_r <= cfg_block_format;
    end
  end

  bc13_issue u_issue (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_alpha_block  (in_alpha_block),
    .in_colour_block (in_colour_block),
    .fmt_bc3         (block_format_r),
    .tok_valid       (tok_valid),
    .tok_ready       (tok_ready),
    .tok             (tok)
  );

  bc13_pix_pipe u_pix_pipe (
    .clk             (clk),
    .rst_n           (rst_n),
    .tok_valid       (tok_valid),
    .tok_ready       (tok_ready),
    .tok             (tok),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel       (out_pixel),
    .out_pixel_index (out_pixel_index),
    .out_last        (out_last)
  );

endmodule
